### sv/ieq_pkg.sv
package ieq_pkg;

	localparam int DEVICE_SLOTS        = 8;
	localparam int SLOT_W              = 3;
	localparam int QUEUE_DEPTH_DEFAULT = 128;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_EMIT = 2'd1,
		OP_POLL = 2'd2,
		OP_GRAB = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_BAD   = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0]       ev_value;
		logic [15:0]       ev_code;
		logic [15:0]       ev_type;
		logic [SLOT_W-1:0] ev_device;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

endpackage

### sv/input_event_queue.sv
// Input event queue: a table of eight device slots and a ring queue of
// QUEUE_DEPTH events held in one synchronous RAM. Each transfer on the slave
// side carries one operation in tuser (add device, emit event, poll event,
// grab device) and yields exactly one result transfer on the master side.
// A poll that finds an event waits in a read state, as the RAM returns the
// oldest entry in the cycle after its address is presented. A new operation
// is taken when no poll is waiting on the RAM and the result register is
// empty or being emptied in that cycle. Slots are never freed, and the grab
// owner is reported in every result.
module input_event_queue #(
	parameter int QUEUE_DEPTH = ieq_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// capability_mask, device_index, event_type, event_code, event_value, zero pad
	input  logic [87:0] s_tdata,
	// operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot_given, out_device, out_type, out_code, out_value, grab_owner, zero pad
	output logic [79:0] m_tdata,
	// status
	output logic [1:0]  m_tuser
);

	import ieq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        fill_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [DEVICE_SLOTS-1:0] slot_used_q;
	logic signed [3:0]    owner_q;

	status_t              res_status_q;
	logic [SLOT_W-1:0]    res_slot_q;
	event_t               res_event_q;

	logic        s_fire;
	op_t         op;
	logic [15:0] cap_mask;
	logic [3:0]  dev_index;
	event_t      in_event;
	event_t      rd_event;
	logic [EVENT_W-1:0] rd_data;

	logic              dev_ok;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [AW:0]       wr_sum;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_ptr_next;
	logic              emit_ok;
	logic              poll_ok;
	status_t           status_now;

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid || m_tready);
	assign s_fire   = s_tvalid && s_tready;

	assign op                 = op_t'(s_tuser);
	assign cap_mask           = s_tdata[15:0];
	assign dev_index          = s_tdata[19:16];
	assign in_event.ev_device = dev_index[SLOT_W-1:0];
	assign in_event.ev_type   = s_tdata[35:20];
	assign in_event.ev_code   = s_tdata[51:36];
	assign in_event.ev_value  = s_tdata[83:52];

	assign dev_ok = (dev_index < 4'(DEVICE_SLOTS)) && slot_used_q[dev_index[SLOT_W-1:0]];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = DEVICE_SLOTS - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign wr_sum  = {1'b0, rd_ptr_q} + (AW + 1)'(fill_q);
	assign wr_addr = (wr_sum >= (AW + 1)'(QUEUE_DEPTH)) ?
		AW'(wr_sum - (AW + 1)'(QUEUE_DEPTH)) : wr_sum[AW-1:0];
	assign rd_ptr_next = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	assign emit_ok = (op == OP_EMIT) && dev_ok && (fill_q < CW'(QUEUE_DEPTH));
	assign poll_ok = (op == OP_POLL) && (fill_q != '0);

	always_comb begin
		unique case (op)
			OP_ADD: begin
				if (cap_mask == '0) begin
					status_now = STAT_BAD;
				end else if (!free_found) begin
					status_now = STAT_FULL;
				end else begin
					status_now = STAT_OK;
				end
			end
			OP_EMIT: begin
				if (!dev_ok) begin
					status_now = STAT_BAD;
				end else if (fill_q >= CW'(QUEUE_DEPTH)) begin
					status_now = STAT_FULL;
				end else begin
					status_now = STAT_OK;
				end
			end
			OP_POLL: begin
				status_now = (fill_q == '0) ? STAT_EMPTY : STAT_OK;
			end
			default: begin
				status_now = dev_ok ? STAT_OK : STAT_BAD;
			end
		endcase
	end

	ieq_ram #(
		.WIDTH(EVENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk    (clk),
		.wr_en  (s_fire && emit_ok),
		.wr_addr(wr_addr),
		.wr_data(in_event),
		.rd_en  (s_fire && poll_ok),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

	assign rd_event = event_t'(rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			rd_ptr_q     <= '0;
			slot_used_q  <= '0;
			owner_q      <= -4'sd1;
			m_tvalid     <= 1'b0;
			res_status_q <= STAT_OK;
			res_slot_q   <= '0;
			res_event_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						res_status_q <= status_now;
						res_event_q  <= '0;
						res_slot_q   <= (op == OP_ADD && status_now == STAT_OK) ?
							free_idx : '0;
						if (op == OP_ADD && status_now == STAT_OK) begin
							slot_used_q[free_idx] <= 1'b1;
						end
						if (emit_ok) begin
							fill_q <= fill_q + 1'b1;
						end
						if (op == OP_GRAB && dev_ok) begin
							owner_q <= signed'(dev_index);
						end
						if (poll_ok) begin
							fill_q   <= fill_q - 1'b1;
							rd_ptr_q <= rd_ptr_next;
							state_q  <= S_READ;
						end
						m_tvalid <= !poll_ok;
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
					end
				end
				S_READ: begin
					res_event_q <= rd_event;
					m_tvalid    <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tuser = res_status_q;
	assign m_tdata = {6'd0, owner_q, res_event_q.ev_value, res_event_q.ev_code,
		res_event_q.ev_type, res_event_q.ev_device, res_slot_q};

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH))
		else $error("Fill count exceeds the queue depth.");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !m_tvalid)
		else $error("Result register busy while a pop is in flight.");

	a_poll_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && poll_ok |=> state_q == S_READ && !s_tready)
		else $error("Poll did not wait for the RAM read.");

	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && emit_ok |=> fill_q == $past(fill_q) + 1'b1)
		else $error("Accepted event was not counted.");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !poll_ok |=> m_tvalid && m_tuser == $past(status_now))
		else $error("Result of a single-cycle operation is missing.");
`endif

endmodule

### sv/ieq_ram.sv
module ieq_ram #(
	parameter int WIDTH = ieq_pkg::EVENT_W,
	parameter int DEPTH = ieq_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
